### hw/rtl/gjr_pkg.sv
// gjr_pkg: shared types, codes and saturation helper for the rref engine
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gjr_pkg;

	typedef logic signed [31:0] data_t;
	typedef logic [3:0]         dim_t;

	localparam logic [1:0] KIND_LOAD   = 2'd0;
	localparam logic [1:0] KIND_SCALE  = 2'd1;
	localparam logic [1:0] KIND_ADD    = 2'd2;
	localparam logic [1:0] KIND_REDUCE = 2'd3;

	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	localparam int QW = 48;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ROP_RA, S_ROP_RB, S_ROP_MUL, S_ROP_WR,
		S_SR_RD, S_SR_CMP, S_SR_DEC,
		S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB,
		S_DV_RD, S_DV_GO, S_DV_WAIT,
		S_EL_RD, S_EL_F,
		S_NM_RD, S_NM_CMP,
		S_EM_RD, S_EM_LD, S_EM_WAIT
	} state_t;

	typedef struct packed {
		logic  start;
		data_t dividend;
		data_t divisor;
	} div_req_t;

	function automatic data_t sat32(input logic signed [49:0] v);
		data_t r;
		if (v > 50'sh0_7FFF_FFFF)
			r = 32'sh7FFF_FFFF;
		else if (v < -50'sh0_8000_0000)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/gjr_if.sv
// gjr_in_if and gjr_out_if: valid/ready channels of the rref engine
// depends on gjr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface gjr_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        kind;
	logic [2:0]        target_row;
	logic [2:0]        source_row;
	logic [2:0]        column;
	gjr_pkg::data_t    value;
	modport source (output valid, kind, target_row, source_row, column, value, input ready);
	modport sink (input valid, kind, target_row, source_row, column, value, output ready);
endinterface

interface gjr_out_if;
	logic              valid;
	logic              ready;
	logic [2:0]        out_row;
	logic [2:0]        out_column;
	gjr_pkg::data_t    out_value;
	logic              last;
	modport source (output valid, out_row, out_column, out_value, last, input ready);
	modport sink (input valid, out_row, out_column, out_value, last, output ready);
endinterface

`default_nettype wire

### hw/rtl/gauss_jordan_rref_engine.sv
// Gauss-Jordan reduction engine: holds a Q16.16 matrix in a one-port store,
// runs row operations, and full reduction with partial pivoting after which
// it streams every entry out row-major. Kind load writes one entry in the
// accepting cycle; scale and add read, multiply and write each active column.
// Reduce runs a sequencer over the store: pivot search compares each row, swap
// exchanges both rows per column, row divide passes each column through the
// divider, elimination adds into every other row, then a leading-entry divide
// pass. Emitting reads each entry, then waits out any receiver stall; the
// engine holds the current result until its transfer and takes no input
// until the last entry is out. The in channel is ready only while the engine
// is idle. Reset clears the store to zero at once and sets both size registers
// to 8. Configuration writes go in through cfg_we/cfg_index/cfg_data while
// idle; the block does not enforce this, the user must.
// Depends on gjr_pkg, gjr_if, gjr_mem and gjr_div.
`timescale 1ns / 1ps
`default_nettype none

module gauss_jordan_rref_engine #(
	parameter int MAX_ROWS = 8,
	parameter int MAX_COLS = 8
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_we,
	input  wire logic  cfg_index,
	input  wire logic [3:0] cfg_data,
	gjr_in_if.sink     in_ch,
	gjr_out_if.source  out_ch
);
	import gjr_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	state_t state_q, state_nx;

	dim_t   rows_q, cols_q, nr, nc;
	dim_t   lead_q, r_q, i_q, c_q, best_q;
	dim_t   lead_nx, r_nx, i_nx, c_nx;
	logic [2:0] arow_q, brow_q;
	logic   found_q, mode_add_q, rop_elim_q, dv_norm_q;
	logic [31:0] bestmag_q, mag;
	data_t  pivot_q, a_q, b_q, rop_res;
	logic signed [32:0] scalar_q;
	logic signed [64:0] prod_q, prod_adj;
	logic signed [48:0] qv;
	logic   in_xfer, out_xfer;
	logic   trow_ok, srow_ok, load_ok;

	logic       mem_we, mem_re;
	logic [2:0] mem_row, mem_col;
	data_t      mem_wdata, rdata;
	logic [AW-1:0] mem_addr;

	div_req_t div_req;
	logic     div_done;
	data_t    div_q;

	logic [2:0] out_row_q, out_col_q;
	data_t      out_val_q;
	logic       out_last_q;

	assign nr = (rows_q == 4'd0) ? 4'd1 : ((rows_q > 4'(MAX_ROWS)) ? 4'(MAX_ROWS) : rows_q);
	assign nc = (cols_q == 4'd0) ? 4'd1 : ((cols_q > 4'(MAX_COLS)) ? 4'(MAX_COLS) : cols_q);

	assign lead_nx = lead_q + 4'd1;
	assign r_nx    = r_q + 4'd1;
	assign i_nx    = i_q + 4'd1;
	assign c_nx    = c_q + 4'd1;

	assign in_xfer  = in_ch.valid && in_ch.ready;
	assign out_xfer = out_ch.valid && out_ch.ready;
	assign trow_ok  = {1'b0, in_ch.target_row} < nr;
	assign srow_ok  = {1'b0, in_ch.source_row} < nr;
	assign load_ok  = ({1'b0, in_ch.target_row} < 4'(MAX_ROWS))
	               && ({1'b0, in_ch.column} < 4'(MAX_COLS));

	assign mag      = rdata[31] ? 32'(-rdata) : 32'(rdata);
	assign prod_adj = prod_q + (prod_q[64] ? 65'sd65535 : 65'sd0);
	assign qv       = prod_adj[64:16];
	assign rop_res  = mode_add_q ? sat32(50'(b_q) + 50'(qv)) : sat32(50'(qv));

	gjr_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.re     (mem_re),
		.addr   (mem_addr),
		.wdata  (mem_wdata),
		.rdata  (rdata)
	);

	gjr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_q)
	);

	assign mem_addr = AW'(7'(mem_row) * 7'(MAX_COLS) + 7'(mem_col));

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					case (in_ch.kind)
						KIND_SCALE:  if (trow_ok) state_nx = S_ROP_RA;
						KIND_ADD:    if (trow_ok && srow_ok) state_nx = S_ROP_RA;
						KIND_REDUCE: state_nx = S_SR_RD;
						default:     state_nx = S_IDLE;
					endcase
				end
			end
			S_ROP_RA:  state_nx = S_ROP_RB;
			S_ROP_RB:  state_nx = S_ROP_MUL;
			S_ROP_MUL: state_nx = S_ROP_WR;
			S_ROP_WR: begin
				if (c_nx != nc)
					state_nx = S_ROP_RA;
				else
					state_nx = rop_elim_q ? S_EL_RD : S_IDLE;
			end
			S_SR_RD:  state_nx = S_SR_CMP;
			S_SR_CMP: state_nx = (i_nx == nr) ? S_SR_DEC : S_SR_RD;
			S_SR_DEC: begin
				if (!found_q)
					state_nx = (lead_nx == nc) ? S_NM_RD : S_SR_RD;
				else
					state_nx = (best_q != r_q) ? S_SW_RA : S_DV_RD;
			end
			S_SW_RA: state_nx = S_SW_RB;
			S_SW_RB: state_nx = S_SW_WA;
			S_SW_WA: state_nx = S_SW_WB;
			S_SW_WB: state_nx = (c_nx == nc) ? S_DV_RD : S_SW_RA;
			S_DV_RD: state_nx = S_DV_GO;
			S_DV_GO: state_nx = S_DV_WAIT;
			S_DV_WAIT: begin
				if (div_done) begin
					if (c_nx != nc)
						state_nx = S_DV_RD;
					else if (!dv_norm_q)
						state_nx = S_EL_RD;
					else
						state_nx = (r_nx == nr) ? S_EM_RD : S_NM_RD;
				end
			end
			S_EL_RD: begin
				if (i_q == nr)
					state_nx = ((r_nx == nr) || (lead_nx == nc)) ? S_NM_RD : S_SR_RD;
				else if (i_q != r_q)
					state_nx = S_EL_F;
			end
			S_EL_F:  state_nx = S_ROP_RA;
			S_NM_RD: state_nx = S_NM_CMP;
			S_NM_CMP: begin
				if (rdata != 32'sd0)
					state_nx = S_DV_RD;
				else if (c_nx != nc)
					state_nx = S_NM_RD;
				else
					state_nx = (r_nx == nr) ? S_EM_RD : S_NM_RD;
			end
			S_EM_RD: state_nx = S_EM_LD;
			S_EM_LD: state_nx = S_EM_WAIT;
			S_EM_WAIT: begin
				if (out_xfer)
					state_nx = out_last_q ? S_IDLE : S_EM_RD;
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_row   = r_q[2:0];
		mem_col   = c_q[2:0];
		mem_wdata = rdata;
		div_req   = '{start: 1'b0, dividend: rdata, divisor: pivot_q};
		case (state_q)
			S_IDLE: begin
				mem_we    = in_xfer && (in_ch.kind == KIND_LOAD) && load_ok;
				mem_row   = in_ch.target_row;
				mem_col   = in_ch.column;
				mem_wdata = in_ch.value;
			end
			S_ROP_RA: begin
				mem_re  = 1'b1;
				mem_row = arow_q;
			end
			S_ROP_RB: begin
				mem_re  = 1'b1;
				mem_row = brow_q;
			end
			S_ROP_WR: begin
				mem_we    = 1'b1;
				mem_row   = brow_q;
				mem_wdata = rop_res;
			end
			S_SR_RD: begin
				mem_re  = 1'b1;
				mem_row = i_q[2:0];
				mem_col = lead_q[2:0];
			end
			S_SW_RA: mem_re = 1'b1;
			S_SW_RB: begin
				mem_re  = 1'b1;
				mem_row = best_q[2:0];
			end
			S_SW_WA: mem_we = 1'b1;
			S_SW_WB: begin
				mem_we    = 1'b1;
				mem_row   = best_q[2:0];
				mem_wdata = a_q;
			end
			S_DV_RD: mem_re = 1'b1;
			S_DV_GO: div_req.start = 1'b1;
			S_DV_WAIT: begin
				mem_we    = div_done;
				mem_wdata = div_q;
			end
			S_EL_RD: begin
				mem_re  = (i_q != nr) && (i_q != r_q);
				mem_row = i_q[2:0];
				mem_col = lead_q[2:0];
			end
			S_NM_RD: mem_re = 1'b1;
			S_EM_RD: mem_re = 1'b1;
			default: mem_re = 1'b0;
		endcase
	end

	assign in_ch.ready       = (state_q == S_IDLE);
	assign out_ch.valid      = (state_q == S_EM_WAIT);
	assign out_ch.out_row    = out_row_q;
	assign out_ch.out_column = out_col_q;
	assign out_ch.out_value  = out_val_q;
	assign out_ch.last       = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rows_q  <= 4'd8;
			cols_q  <= 4'd8;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				case (cfg_index)
					REG_ROWS: rows_q <= cfg_data;
					REG_COLS: cols_q <= cfg_data;
					default:  rows_q <= rows_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q     <= '0;
			r_q        <= '0;
			i_q        <= '0;
			c_q        <= '0;
			best_q     <= '0;
			found_q    <= 1'b0;
			mode_add_q <= 1'b0;
			rop_elim_q <= 1'b0;
			dv_norm_q  <= 1'b0;
			arow_q     <= '0;
			brow_q     <= '0;
			bestmag_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					c_q        <= '0;
					rop_elim_q <= 1'b0;
					dv_norm_q  <= 1'b0;
					lead_q     <= '0;
					r_q        <= '0;
					i_q        <= '0;
					found_q    <= 1'b0;
					bestmag_q  <= '0;
					arow_q     <= (in_ch.kind == KIND_ADD) ? in_ch.source_row : in_ch.target_row;
					brow_q     <= in_ch.target_row;
					mode_add_q <= (in_ch.kind == KIND_ADD);
				end
				S_ROP_WR: begin
					if (c_nx != nc)
						c_q <= c_nx;
					else
						i_q <= i_nx;
				end
				S_SR_CMP: begin
					if (mag > bestmag_q) begin
						bestmag_q <= mag;
						best_q    <= i_q;
						found_q   <= 1'b1;
					end
					i_q <= i_nx;
				end
				S_SR_DEC: begin
					c_q <= '0;
					if (!found_q) begin
						lead_q    <= lead_nx;
						i_q       <= r_q;
						bestmag_q <= '0;
						if (lead_nx == nc)
							r_q <= '0;
					end
				end
				S_SW_WB: c_q <= (c_nx == nc) ? 4'd0 : c_nx;
				S_DV_WAIT: begin
					if (div_done) begin
						if (c_nx != nc)
							c_q <= c_nx;
						else begin
							c_q <= '0;
							i_q <= '0;
							if (dv_norm_q)
								r_q <= (r_nx == nr) ? 4'd0 : r_nx;
						end
					end
				end
				S_EL_RD: begin
					if (i_q == nr) begin
						lead_q    <= lead_nx;
						found_q   <= 1'b0;
						bestmag_q <= '0;
						c_q       <= '0;
						if ((r_nx == nr) || (lead_nx == nc)) begin
							r_q <= '0;
						end else begin
							r_q <= r_nx;
							i_q <= r_nx;
						end
					end else if (i_q == r_q) begin
						i_q <= i_nx;
					end
				end
				S_EL_F: begin
					arow_q     <= r_q[2:0];
					brow_q     <= i_q[2:0];
					mode_add_q <= 1'b1;
					rop_elim_q <= 1'b1;
					c_q        <= '0;
				end
				S_NM_CMP: begin
					if (rdata != 32'sd0) begin
						c_q       <= '0;
						dv_norm_q <= 1'b1;
					end else if (c_nx != nc) begin
						c_q <= c_nx;
					end else begin
						c_q <= '0;
						r_q <= (r_nx == nr) ? 4'd0 : r_nx;
					end
				end
				S_EM_WAIT: begin
					if (out_xfer) begin
						if (c_nx != nc)
							c_q <= c_nx;
						else begin
							c_q <= '0;
							r_q <= r_nx;
						end
					end
				end
				default: c_q <= c_q;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE:    scalar_q <= {in_ch.value[31], in_ch.value};
			S_ROP_RB:  a_q <= rdata;
			S_ROP_MUL: begin
				b_q    <= rdata;
				prod_q <= scalar_q * 65'(a_q);
			end
			S_SR_CMP:  if (mag > bestmag_q) pivot_q <= rdata;
			S_SW_RB:   a_q <= rdata;
			S_EL_F:    scalar_q <= -{rdata[31], rdata};
			S_NM_CMP:  if (rdata != 32'sd0) pivot_q <= rdata;
			S_EM_LD: begin
				out_row_q  <= r_q[2:0];
				out_col_q  <= c_q[2:0];
				out_val_q  <= rdata;
				out_last_q <= (r_nx == nr) && (c_nx == nc);
			end
			default: a_q <= a_q;
		endcase
	end

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !out_ch.valid)
		else $error("input accepted while a result is pending");

	a_port_single: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("store read and write in the same cycle");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && out_ch.last) |=> in_ch.ready)
		else $error("engine not idle after final transfer");

	a_div_write: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DV_WAIT))
		else $error("quotient arrived outside the divide step");
`endif

endmodule

`default_nettype wire

### hw/rtl/gjr_mem.sv
// gjr_mem: matrix store, one port, registered read, zero until written
// depends on gjr_pkg
`timescale 1ns / 1ps
`default_nettype none

module gjr_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            we,
	input  wire logic            re,
	input  wire logic [AW-1:0]   addr,
	input  wire gjr_pkg::data_t  wdata,
	output gjr_pkg::data_t       rdata
);
	import gjr_pkg::*;

	data_t             ram [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	data_t             rd_q;
	logic              rd_vld_q;

	always_ff @(posedge clk) begin
		if (we)
			ram[addr] <= wdata;
		if (re)
			rd_q <= ram[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (we)
				vld_q[addr] <= 1'b1;
			if (re)
				rd_vld_q <= vld_q[addr];
		end
	end

	assign rdata = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

### hw/rtl/gjr_div.sv
// gjr_div: Q16.16 quotient, one bit per cycle, truncating, saturated
// depends on gjr_pkg
`timescale 1ns / 1ps
`default_nettype none

module gjr_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire gjr_pkg::div_req_t req,
	output logic                   done,
	output gjr_pkg::data_t         quotient
);
	import gjr_pkg::*;

	logic            busy_q;
	logic            done_q;
	logic [5:0]      cnt_q;
	logic [QW-1:0]   quo_q;
	logic [32:0]     rem_q;
	logic [31:0]     ub_q;
	logic            neg_q;
	logic [32:0]     rem_sh;
	logic            ge;
	logic [31:0]     ua;
	logic [31:0]     ub;

	assign ua     = req.dividend[31] ? 32'(-req.dividend) : 32'(req.dividend);
	assign ub     = req.divisor[31] ? 32'(-req.divisor) : 32'(req.divisor);
	assign rem_sh = {rem_q[31:0], quo_q[QW-1]};
	assign ge     = rem_sh >= {1'b0, ub_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			ub_q   <= '0;
			neg_q  <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(QW);
				quo_q  <= {ua, 16'h0000};
				rem_q  <= '0;
				ub_q   <= ub;
				neg_q  <= req.dividend[31] ^ req.divisor[31];
			end else if (busy_q) begin
				rem_q <= ge ? (rem_sh - {1'b0, ub_q}) : rem_sh;
				quo_q <= {quo_q[QW-2:0], ge};
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1)
					busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (neg_q)
			quotient = (quo_q > 48'h0000_8000_0000) ? 32'sh8000_0000 : -data_t'(quo_q[31:0]);
		else
			quotient = (quo_q > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : data_t'(quo_q[31:0]);
	end

	assign done = done_q;

endmodule

`default_nettype wire
